[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLKD(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[src/smr90_pkg.sv]
// ----------------------------------------------------------------------------
// smr90_pkg
// Shared constants, command codes, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package smr90_pkg;

  localparam int MAX_SIDE_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int SIDE_W  = 5;   // matrix_side register width
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;   // row / column field width
  localparam int VALUE_W = 32;  // write_value / read_value width

  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_ROT_READ,
    ST_ROT_WRITE,
    ST_FINISH
  } state_t;

  // Ring position of one element of a group of four
  typedef enum logic [1:0] {
    POS_TOP    = 2'd0,
    POS_LEFT   = 2'd1,
    POS_BOTTOM = 2'd2,
    POS_RIGHT  = 2'd3
  } pos_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic host_sel;  // address and data come from the input word
    pos_t pos;       // ring position during a rotation
  } mem_ctl_t;

endpackage

[src/square_matrix_rotate_90.sv]
// ----------------------------------------------------------------------------
// square_matrix_rotate_90
// Square matrix store with host read/write and in-place clockwise rotation.
// ----------------------------------------------------------------------------
// Holds a MAX_SIDE x MAX_SIDE matrix of ELEMENT_WIDTH-bit signed elements in
// one single-port memory (row-major, row stride MAX_SIDE); the side in use is
// the cfg register, capped at MAX_SIDE. Each accepted word yields exactly one
// result word. A write or an unused/flagged command goes through the finish
// state before the next accept; a read also passes the read-wait state for the
// registered memory read. In a rotate, every group of four ring elements costs
// four reads and four writes, all through the one memory port, which sets the
// rate. The input is not ready while a command is in progress; a finished
// result waits in the output register, and the next word is accepted while it
// waits. Entries must be written before a rotate or read touches them; the
// store is not cleared at reset. Write cfg only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module square_matrix_rotate_90 #(
  parameter int MAX_SIDE      = smr90_pkg::MAX_SIDE_DEF,
  parameter int ELEMENT_WIDTH = smr90_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[3:0], column[7:4], write_value[39:8]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_value[31:0]
  output logic [0:0]  m_tuser,   // index_error[0]
  // matrix_side register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // matrix_side[4:0]
);

  localparam int IW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // Unpack the input word
  smr90_pkg::cmd_t                     cmd;
  logic [smr90_pkg::IDX_W-1:0]         row;
  logic [smr90_pkg::IDX_W-1:0]         column;
  logic [smr90_pkg::VALUE_W-1:0]       write_value;

  assign cmd         = smr90_pkg::cmd_t'(s_tuser[1:0]);
  assign row         = s_tdata[3:0];
  assign column      = s_tdata[7:4];
  assign write_value = s_tdata[39:8];

  // Configuration: ready outside reset; the user must write it only while idle, the block does not enforce this
  logic [smr90_pkg::SIDE_W-1:0] matrix_side;
  logic [smr90_pkg::SIDE_W-1:0] eff_side;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_side <= smr90_pkg::SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_side <= cfg_data;
    end
  end

  // Cap the side at the physical size of the store
  assign eff_side = (int'(matrix_side) > MAX_SIDE) ? smr90_pkg::SIDE_W'(MAX_SIDE)
                                                   : matrix_side;

  logic take;
  logic idx_ok;
  logic out_free;

  assign take     = s_tvalid && s_tready;
  assign idx_ok   = ({1'b0, row} < eff_side) && ({1'b0, column} < eff_side);
  assign out_free = !m_tvalid || m_tready;

  // Sequencer
  smr90_pkg::mem_ctl_t ctl;
  logic                finish;
  logic [IW-1:0]       ring, k, last, opp;

  smr90_seq #(
    .MAX_SIDE (MAX_SIDE),
    .IW       (IW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (cmd),
    .idx_ok   (idx_ok),
    .eff_side (eff_side),
    .out_free (out_free),
    .ready    (s_tready),
    .finish   (finish),
    .ctl      (ctl),
    .ring     (ring),
    .k        (k),
    .last     (last),
    .opp      (opp)
  );

  // Shared address unit
  logic [AW-1:0] addr;

  smr90_agen #(
    .MAX_SIDE (MAX_SIDE),
    .IW       (IW),
    .AW       (AW)
  ) u_agen (
    .host_sel (ctl.host_sel),
    .pos      (ctl.pos),
    .host_row (row),
    .host_col (column),
    .ring     (ring),
    .k        (k),
    .last     (last),
    .opp      (opp),
    .addr     (addr)
  );

  // Rotation holding registers: one per ring position of the current group
  logic [ELEMENT_WIDTH-1:0] held [4];
  logic                     cap_en;
  logic [1:0]               cap_slot;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic [1:0]               src_slot;

  // Each position takes the element from the next one counterclockwise
  assign src_slot = ctl.pos + 2'd1;
  assign wdata    = ctl.host_sel ? ELEMENT_WIDTH'($signed(write_value)) : held[src_slot];

  smr90_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .rd_en (ctl.rd_en),
    .wr_en (ctl.wr_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_en <= 1'b0;
    end else begin
      cap_en <= ctl.rd_en && !ctl.host_sel;
    end
  end

  always_ff @(posedge clk) begin
    cap_slot <= ctl.pos;
    if (cap_en) begin
      held[cap_slot] <= rdata;
    end
  end

  // Result flags, latched when the word is accepted
  logic res_err;
  logic res_mem;

  always_ff @(posedge clk) begin
    if (take) begin
      res_err <= ((cmd == smr90_pkg::CMD_WRITE) || (cmd == smr90_pkg::CMD_READ)) && !idx_ok;
      res_mem <= (cmd == smr90_pkg::CMD_READ) && idx_ok;
    end
  end

  // Output register; read data holds in the memory until loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata    <= res_mem ? smr90_pkg::VALUE_W'($signed(rdata)) : '0;
      m_tuser[0] <= res_err;
    end
  end

  // Assertions
  logic rot_rd_right;
  logic rot_wr_top;
  logic host_rd;

  assign rot_rd_right = ctl.rd_en && !ctl.host_sel && (ctl.pos == smr90_pkg::POS_RIGHT);
  assign rot_wr_top   = ctl.wr_en && !ctl.host_sel && (ctl.pos == smr90_pkg::POS_TOP);
  assign host_rd      = ctl.rd_en && ctl.host_sel;

  `ASSERT_NEVER(a_port_conflict, clk, rst, ctl.rd_en && ctl.wr_en, "read and write in one cycle")
  `ASSERT_CLKD(a_group_order, clk, rst, rot_rd_right |=> rot_wr_top, "group writes out of order")
  `ASSERT_CLKD(a_read_hold, clk, rst, host_rd |=> !(ctl.rd_en || ctl.wr_en), "port busy on read")
  `ASSERT_CLKD(a_load_free, clk, rst, finish |-> out_free, "result loaded over a waiting word")

endmodule

[src/smr90_mem.sv]
// ----------------------------------------------------------------------------
// smr90_mem
// Single-port element store with registered read data.
// ----------------------------------------------------------------------------
module smr90_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/smr90_agen.sv]
// ----------------------------------------------------------------------------
// smr90_agen
// Shared address unit: picks a row and column and forms the row-major address.
// ----------------------------------------------------------------------------
module smr90_agen #(
  parameter int MAX_SIDE = smr90_pkg::MAX_SIDE_DEF,
  parameter int IW       = $clog2(MAX_SIDE),
  parameter int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic                        host_sel,
  input  smr90_pkg::pos_t             pos,
  input  logic [smr90_pkg::IDX_W-1:0] host_row,
  input  logic [smr90_pkg::IDX_W-1:0] host_col,
  input  logic [IW-1:0]               ring,
  input  logic [IW-1:0]               k,
  input  logic [IW-1:0]               last,
  input  logic [IW-1:0]               opp,
  output logic [AW-1:0]               addr
);

  logic [IW-1:0] sel_row;
  logic [IW-1:0] sel_col;

  always_comb begin
    sel_row = IW'(host_row);
    sel_col = IW'(host_col);
    if (!host_sel) begin
      case (pos)
        smr90_pkg::POS_TOP: begin
          sel_row = ring;
          sel_col = k;
        end
        smr90_pkg::POS_LEFT: begin
          sel_row = opp;
          sel_col = ring;
        end
        smr90_pkg::POS_BOTTOM: begin
          sel_row = last;
          sel_col = opp;
        end
        smr90_pkg::POS_RIGHT: begin
          sel_row = k;
          sel_col = last;
        end
        default: begin
          sel_row = ring;
          sel_col = k;
        end
      endcase
    end
  end

  assign addr = AW'(sel_row) * AW'(MAX_SIDE) + AW'(sel_col);

endmodule

[src/smr90_seq.sv]
// ----------------------------------------------------------------------------
// smr90_seq
// Command sequencer: host accesses and the ring walk of a rotation.
// ----------------------------------------------------------------------------
module smr90_seq #(
  parameter int MAX_SIDE = smr90_pkg::MAX_SIDE_DEF,
  parameter int IW       = $clog2(MAX_SIDE)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  smr90_pkg::cmd_t              cmd,
  input  logic                         idx_ok,
  input  logic [smr90_pkg::SIDE_W-1:0] eff_side,
  input  logic                         out_free,
  output logic                         ready,
  output logic                         finish,
  output smr90_pkg::mem_ctl_t          ctl,
  output logic [IW-1:0]                ring,
  output logic [IW-1:0]                k,
  output logic [IW-1:0]                last,
  output logic [IW-1:0]                opp
);

  smr90_pkg::state_t state, state_next;
  logic [IW-1:0]     ring_next, k_next;
  logic [1:0]        phase, phase_next;
  logic [IW-1:0]     side_m1;
  logic [IW-1:0]     span;
  logic [IW-1:0]     k_inc;

  assign side_m1 = IW'(eff_side - smr90_pkg::SIDE_W'(1));
  assign last    = side_m1 - ring;
  assign opp     = side_m1 - k;
  assign span    = last - ring;
  assign k_inc   = k + IW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smr90_pkg::ST_IDLE;
      ring  <= '0;
      k     <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      ring  <= ring_next;
      k     <= k_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next   = state;
    ring_next    = ring;
    k_next       = k;
    phase_next   = phase;
    ready        = 1'b0;
    finish       = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.wr_en    = 1'b0;
    ctl.host_sel = 1'b0;
    ctl.pos      = smr90_pkg::pos_t'(phase);

    case (state)
      smr90_pkg::ST_IDLE: begin
        // hold off input words while in reset
        ready        = !rst;
        ctl.host_sel = 1'b1;
        if (take) begin
          case (cmd)
            smr90_pkg::CMD_WRITE: begin
              ctl.wr_en  = idx_ok;
              state_next = smr90_pkg::ST_FINISH;
            end
            smr90_pkg::CMD_READ: begin
              ctl.rd_en  = idx_ok;
              state_next = idx_ok ? smr90_pkg::ST_READ_WAIT : smr90_pkg::ST_FINISH;
            end
            smr90_pkg::CMD_ROTATE: begin
              ring_next  = '0;
              k_next     = '0;
              phase_next = '0;
              // a side of one or zero has no ring to turn
              state_next = (eff_side >= smr90_pkg::SIDE_W'(2)) ?
                           smr90_pkg::ST_ROT_READ : smr90_pkg::ST_FINISH;
            end
            default: begin
              state_next = smr90_pkg::ST_FINISH;
            end
          endcase
        end
      end

      smr90_pkg::ST_READ_WAIT: begin
        state_next = smr90_pkg::ST_FINISH;
      end

      smr90_pkg::ST_ROT_READ: begin
        ctl.rd_en  = 1'b1;
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          state_next = smr90_pkg::ST_ROT_WRITE;
        end
      end

      smr90_pkg::ST_ROT_WRITE: begin
        ctl.wr_en  = 1'b1;
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          if (k_inc < last) begin
            k_next     = k_inc;
            state_next = smr90_pkg::ST_ROT_READ;
          end else if ({1'b0, span} >= (IW + 1)'(3)) begin
            // next ring inward still has a group
            ring_next  = ring + IW'(1);
            k_next     = ring + IW'(1);
            state_next = smr90_pkg::ST_ROT_READ;
          end else begin
            state_next = smr90_pkg::ST_FINISH;
          end
        end
      end

      smr90_pkg::ST_FINISH: begin
        finish = out_free;
        if (out_free) begin
          state_next = smr90_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = smr90_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for square_matrix_rotate_90: fills the whole store,
// then runs corner, flag and unused-command words at the extreme sides, then
// random write/read/rotate traffic over a series of matrix sides. A local
// copy of the matrix predicts every result word; results are checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASE_WORDS = 130;

  // One input word as the block sees it
  typedef struct packed {
    smr90_pkg::cmd_t command;
    logic [3:0]      row;
    logic [3:0]      column;
    logic [31:0]     write_value;
  } matrix_word_t;

  // One result word
  typedef struct {
    logic [31:0] read_value;
    logic        index_error;
  } matrix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // row[3:0], column[7:4], write_value[39:8]
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // read_value[31:0]
  logic [0:0]  m_tuser;        // index_error[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;  // matrix_side[4:0]

  // Words waiting to be sent, and results the local matrix says are due
  matrix_word_t   cmd_queue[$];
  matrix_result_t awaited_results[$];

  // Local copy of the store and of the side register
  logic [31:0] grid [smr90_pkg::MAX_SIDE_DEF][smr90_pkg::MAX_SIDE_DEF];
  logic [4:0]  grid_side = smr90_pkg::SIDE_RESET;

  matrix_word_t cur_word;
  int gap_pct = 0, stall_pct = 0;   // chance of starting an idle burst
  int gap_left = 0, stall_left = 0;
  int fail_count = 0;
  int n_words = 0, n_writes = 0, n_reads = 0, n_rotates = 0, n_flagged = 0;
  int n_unused = 0, n_results = 0, n_side_writes = 0;

  square_matrix_rotate_90 DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Turn the n x n corner of the local matrix clockwise, ring by ring from
  // the outside, moving each group of four one step around its ring.
  task automatic turn_grid(input int n);
    int last_k, opp;
    logic [31:0] held;
    for (int ring = 0; ring < n / 2; ring++) begin
      last_k = n - 1 - ring;
      for (int k = ring; k < last_k; k++) begin
        opp = n - 1 - k;
        held = grid[ring][k];
        grid[ring][k] = grid[opp][ring];
        grid[opp][ring] = grid[last_k][opp];
        grid[last_k][opp] = grid[k][last_k];
        grid[k][last_k] = held;
      end
    end
  endtask

  // Apply one accepted word to the local matrix and queue the result it owes
  task automatic run_matrix_cmd(input matrix_word_t w);
    matrix_result_t res;
    int n;
    n = (grid_side > smr90_pkg::MAX_SIDE_DEF) ? smr90_pkg::MAX_SIDE_DEF : grid_side;
    res.read_value = '0;
    res.index_error = 1'b0;
    n_words++;
    case (w.command)
      smr90_pkg::CMD_WRITE, smr90_pkg::CMD_READ: begin
        if (w.row >= n || w.column >= n) begin
          res.index_error = 1'b1;
          n_flagged++;
        end else if (w.command == smr90_pkg::CMD_WRITE) begin
          grid[w.row][w.column] = w.write_value;
          n_writes++;
        end else begin
          res.read_value = grid[w.row][w.column];
          n_reads++;
        end
      end
      smr90_pkg::CMD_ROTATE: begin
        turn_grid(n);
        n_rotates++;
      end
      default: n_unused++;
    endcase
    awaited_results.push_back(res);
  endtask

  // Driver: send queued words, with random gap bursts between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        run_matrix_cmd(cur_word);
      // Slot is free when nothing is held or the held word just went in
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(5, 1) - 1;
          s_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_word = cmd_queue.pop_front();
          s_tdata  <= {cur_word.write_value, cur_word.column, cur_word.row};
          s_tuser  <= cur_word.command;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest one due
  always @(posedge clk) begin
    matrix_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: read_value %h index_error %b",
                     m_tdata, m_tuser[0]);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata !== want.read_value || m_tuser[0] !== want.index_error) begin
            if (fail_count < 10)
              $display("result %0d: read_value exp %h got %h, index_error exp %b got %b",
                       n_results, want.read_value, m_tdata, want.index_error, m_tuser[0]);
            fail_count++;
          end
        end
      end
      // Stall in bursts of random length
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(5, 1) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Hold until every queued word is in and every result word has come back;
  // look at the falling edge so the rising-edge updates have all settled
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || s_tvalid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  // Write the side register while the block is idle
  task automatic load_side(input logic [4:0] side);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_data  <= side;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    grid_side = side;
    n_side_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input smr90_pkg::cmd_t cmd, input int r, input int c,
                            input logic [31:0] v);
    matrix_word_t w;
    w.command = cmd;
    w.row = 4'(r);
    w.column = 4'(c);
    w.write_value = v;
    cmd_queue.push_back(w);
  endtask

  // Mostly in-range writes and reads, some rotates, a few flagged indexes
  // and unused commands; values lean on the extremes now and then.
  function automatic matrix_word_t random_word(input int n);
    matrix_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.write_value = $urandom;
    w.row = 4'($urandom_range(15));
    w.column = 4'($urandom_range(15));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: w.write_value = '0;
        1: w.write_value = '1;
        2: w.write_value = 32'h7fff_ffff;
        default: w.write_value = 32'h8000_0000;
      endcase
    end
    if (pick < 40) w.command = smr90_pkg::CMD_WRITE;
    else if (pick < 80) w.command = smr90_pkg::CMD_READ;
    else if (pick < 92) w.command = smr90_pkg::CMD_ROTATE;
    else w.command = smr90_pkg::CMD_NONE;
    if ((w.command == smr90_pkg::CMD_WRITE || w.command == smr90_pkg::CMD_READ) && n > 0) begin
      w.row = 4'($urandom_range(n - 1));
      w.column = 4'($urandom_range(n - 1));
      if (n < smr90_pkg::MAX_SIDE_DEF && $urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: w.row = 4'($urandom_range(15, n));
          1: w.column = 4'($urandom_range(15, n));
          default: begin
            w.row = 4'($urandom_range(15, n));
            w.column = 4'($urandom_range(15, n));
          end
        endcase
      end
    end
    return w;
  endfunction

  initial begin
    int side_plan[12];
    int n;
    side_plan = '{5, 2, 3, 16, 1, 9, 0, 31, 4, 16, 12, 7};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole store so no later read or rotate touches a stale entry
    gap_pct = 20;
    stall_pct = 20;
    load_side(5'd16);
    for (int r = 0; r < smr90_pkg::MAX_SIDE_DEF; r++)
      for (int c = 0; c < smr90_pkg::MAX_SIDE_DEF; c++)
        queue_word(smr90_pkg::CMD_WRITE, r, c, $urandom);

    // Corners with extreme values, a full-size turn, unused commands
    queue_word(smr90_pkg::CMD_WRITE, 0, 0, 32'h7fff_ffff);
    queue_word(smr90_pkg::CMD_WRITE, 15, 15, 32'h8000_0000);
    queue_word(smr90_pkg::CMD_WRITE, 0, 15, 32'hffff_ffff);
    queue_word(smr90_pkg::CMD_WRITE, 15, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 15, 15, 32'hffff_ffff);
    queue_word(smr90_pkg::CMD_ROTATE, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 15, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 15, 15, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 15, 0, 32'h0);
    queue_word(smr90_pkg::CMD_NONE, 15, 15, 32'hffff_ffff);
    queue_word(smr90_pkg::CMD_NONE, 0, 0, 32'h0);

    // Side of one: a turn changes nothing, anything past the corner is flagged
    load_side(5'd1);
    queue_word(smr90_pkg::CMD_WRITE, 0, 0, 32'h8000_0001);
    queue_word(smr90_pkg::CMD_ROTATE, 15, 15, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 1, 32'h0);
    queue_word(smr90_pkg::CMD_WRITE, 1, 0, 32'h1234_5678);
    queue_word(smr90_pkg::CMD_WRITE, 15, 15, 32'hffff_ffff);

    // Side of zero: everything flagged, a turn does nothing
    load_side(5'd0);
    queue_word(smr90_pkg::CMD_WRITE, 0, 0, 32'h5555_5555);
    queue_word(smr90_pkg::CMD_ROTATE, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 0, 0, 32'h0);

    // Side above the store: clamps to the full matrix
    load_side(5'd31);
    queue_word(smr90_pkg::CMD_ROTATE, 0, 0, 32'h0);
    queue_word(smr90_pkg::CMD_READ, 15, 15, 32'h0);
    queue_word(smr90_pkg::CMD_WRITE, 15, 15, 32'haaaa_aaaa);
    queue_word(smr90_pkg::CMD_READ, 15, 15, 32'h0);

    // Random traffic per side; every third phase and the last run without idling
    foreach (side_plan[p]) begin
      n = (side_plan[p] > smr90_pkg::MAX_SIDE_DEF) ? smr90_pkg::MAX_SIDE_DEF : side_plan[p];
      gap_pct   = (p % 3 == 2 || p == $size(side_plan) - 1) ? 0 : 25;
      stall_pct = (p % 3 == 2 || p == $size(side_plan) - 1) ? 0 : 25;
      load_side(5'(side_plan[p]));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Hold the sender halfway until the block has answered everything
        if (i == PHASE_WORDS / 2)
          wait_drained();
        cmd_queue.push_back(random_word(n));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d words: %0d writes, %0d reads, %0d rotates, %0d flagged, %0d unused",
             n_words, n_writes, n_reads, n_rotates, n_flagged, n_unused);
    $display("Side register loaded %0d times, from 0 through 31 (clamped at 16)",
             n_side_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d result words failed", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Drop the run if the block stops answering
  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
